/* src/sdem_pkg.sv */
// ----------------------------------------------------------------------------
// sdem_pkg: shared types and constants of the edge map
// Frame limits, field widths, register indexes and the queue item that the
// front end hands to the back end.
// ----------------------------------------------------------------------------
package sdem_pkg;

  localparam int unsigned MaxWidth  = 1024;
  localparam int unsigned MaxHeight = 4095;

  localparam int unsigned PixW    = 8;
  localparam int unsigned ColW    = $clog2(MaxWidth);
  localparam int unsigned WidthW  = 11;
  localparam int unsigned HeightW = 12;
  // Rows run two beyond the frame while the last rows drain.
  localparam int unsigned RowW    = $clog2(MaxHeight + 2);

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);

  localparam logic [WidthW-1:0]  WidthReset  = WidthW'(640);
  localparam logic [HeightW-1:0] HeightReset = HeightW'(480);

  localparam logic FuncPixel = 1'b0;
  localparam logic FuncFlush = 1'b1;

  localparam logic [PixW-1:0] EdgeMark = 8'hFF;
  localparam logic [PixW-1:0] EdgeNone = 8'h00;
  localparam logic [PixW-1:0] MagMax   = 8'hFF;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // One classified position on its way to the back end.
  typedef struct packed {
    logic [PixW-1:0] pix;        // pixel value, zero beyond the frame
    logic [ColW-1:0] col;
    logic            par;        // parity of the input row
    logic            left_ok;    // a left neighbour exists
    logic            right_ok;   // a right neighbour exists
    logic            mag_en;     // the row above lies in the frame
    logic            res_en;     // a result is due (two rows down)
    logic            mag_up_ok;  // the result row has a row above it
    logic            last;       // final pixel of the frame
  } item_t;

endpackage

/* src/sdem_front.sv */
// ----------------------------------------------------------------------------
// sdem_front: input acceptance and classification
// Holds the frame geometry and the raster position, drops early flush beats
// and tags every other beat with the neighbour and row flags it needs.
// ----------------------------------------------------------------------------
module sdem_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [sdem_pkg::PixW-1:0]      pixel_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdem_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sdem_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                           q_full_i,
  output logic                           push_o,
  output sdem_pkg::item_t                item_o
);

  logic [sdem_pkg::WidthW-1:0]  width_q, width_d, wr_width;
  logic [sdem_pkg::HeightW-1:0] height_q, height_d, wr_height;
  logic [sdem_pkg::RowW-1:0]    row_q, row_d, h_ext;
  logic [sdem_pkg::ColW-1:0]    col_q, col_d;
  logic [sdem_pkg::WidthW-1:0]  width_m1;
  logic                         col_end, row_lt_h, row_le_h, row_end;
  logic                         accept, drop, cfg_hit;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;

  always_comb begin
    wr_width = cfg_data_i[sdem_pkg::WidthW-1:0];
    if (wr_width == '0) begin
      wr_width = sdem_pkg::WidthW'(1);
    end else if (wr_width > sdem_pkg::WidthW'(sdem_pkg::MaxWidth)) begin
      wr_width = sdem_pkg::WidthW'(sdem_pkg::MaxWidth);
    end
    wr_height = cfg_data_i[sdem_pkg::HeightW-1:0];
    if (wr_height == '0) begin
      wr_height = sdem_pkg::HeightW'(1);
    end else if (wr_height > sdem_pkg::HeightW'(sdem_pkg::MaxHeight)) begin
      wr_height = sdem_pkg::HeightW'(sdem_pkg::MaxHeight);
    end
  end

  always_comb begin
    width_m1 = width_q - sdem_pkg::WidthW'(1);
    h_ext    = sdem_pkg::RowW'(height_q);
    col_end  = (sdem_pkg::WidthW'(col_q) == width_m1);
    row_lt_h = (row_q < h_ext);
    row_le_h = (row_q <= h_ext);
    row_end  = (row_q == h_ext + sdem_pkg::RowW'(1));

    accept = in_valid_i && in_ready_o;
    // A flush beat inside the frame is swallowed without effect.
    drop   = row_lt_h && (func_i == sdem_pkg::FuncFlush);
    push_o = accept && !drop;

    item_o.pix       = row_lt_h ? pixel_i : '0;
    item_o.col       = col_q;
    item_o.par       = row_q[0];
    item_o.left_ok   = (col_q != '0);
    item_o.right_ok  = !col_end;
    item_o.mag_en    = (row_q != '0) && row_le_h;
    item_o.res_en    = (row_q >= sdem_pkg::RowW'(2));
    item_o.mag_up_ok = (row_q >= sdem_pkg::RowW'(3));
    item_o.last      = row_end && col_end;
  end

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    row_d    = row_q;
    col_d    = col_q;
    cfg_hit  = 1'b0;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sdem_pkg::CfgImageWidth: begin
          width_d = wr_width;
          cfg_hit = 1'b1;
        end
        sdem_pkg::CfgImageHeight: begin
          height_d = wr_height;
          cfg_hit  = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    if (cfg_hit) begin
      row_d = '0;
      col_d = '0;
    end else if (push_o) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_q + sdem_pkg::RowW'(1);
      end else begin
        col_d = col_q + sdem_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sdem_pkg::WidthReset;
      height_q <= sdem_pkg::HeightReset;
      row_q    <= '0;
      col_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      row_q    <= row_d;
      col_q    <= col_d;
    end
  end

endmodule

/* src/sdem_queue.sv */
// ----------------------------------------------------------------------------
// sdem_queue: short item queue between front and back end
// A small circular buffer that lets either side stall on its own.
// ----------------------------------------------------------------------------
module sdem_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sdem_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output sdem_pkg::item_t item_o
);

  sdem_pkg::item_t                store_q [sdem_pkg::QueueDepth];
  logic [sdem_pkg::QueuePtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [sdem_pkg::QueuePtrW:0]   count_q, count_d;
  logic                           do_push, do_pop;

  assign full_o  = (count_q == (sdem_pkg::QueuePtrW+1)'(sdem_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign item_o  = store_q[rd_ptr_q];

  always_comb begin
    do_push  = push_i && !full_o;
    do_pop   = pop_i && valid_o;
    wr_ptr_d = do_push ? wr_ptr_q + sdem_pkg::QueuePtrW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + sdem_pkg::QueuePtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (sdem_pkg::QueuePtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (sdem_pkg::QueuePtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

/* src/sdem_back.sv */
// ----------------------------------------------------------------------------
// sdem_back: line buffers, magnitude and edge mark
// Reads both row buffers as an item leaves the queue, then forms the squared
// second differences and the zero-crossing mark and drives the result
// register.
// ----------------------------------------------------------------------------
module sdem_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  sdem_pkg::item_t            q_item_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [sdem_pkg::PixW-1:0]  edge_res_o,
  output logic                       last_o
);

  // Two banks per buffer, selected by row parity.
  logic [sdem_pkg::PixW-1:0] pix_mem [2][sdem_pkg::MaxWidth];
  logic [sdem_pkg::PixW-1:0] mag_mem [2][sdem_pkg::MaxWidth];

  logic [sdem_pkg::PixW-1:0] pix_rd_a_q [2];
  logic [sdem_pkg::PixW-1:0] pix_rd_b_q [2];
  logic [sdem_pkg::PixW-1:0] mag_rd_a_q [2];
  logic [sdem_pkg::PixW-1:0] mag_rd_b_q [2];

  sdem_pkg::item_t           s1_q;
  logic                      s1_valid_q, s1_valid_d;
  logic [sdem_pkg::PixW-1:0] pix_left_q, mag_left_q, fwd_val_q;
  logic                      fwd_c_q, fwd_r_q, fwd_u_q;
  logic                      fwd_c_d, fwd_r_d, fwd_u_d;

  logic                      out_valid_q, out_valid_d;
  logic [sdem_pkg::PixW-1:0] edge_q;
  logic                      last_q;

  logic [sdem_pkg::ColW-1:0] h_col_nx;
  logic                      cur, prv, s1_leave;
  logic [sdem_pkg::PixW-1:0] pix_c, pl, pr, pu, pd, dx, dy;
  logic [2*sdem_pkg::PixW-1:0] sq_x, sq_y;
  logic [2*sdem_pkg::PixW:0]   sq_sum;
  logic [sdem_pkg::PixW-1:0] new_mag, mc, mr_eff, mu_eff, ml, mr, mu;
  logic                      mark;

  always_comb begin
    cur = s1_q.par;
    prv = !s1_q.par;

    // Second differences of the pixel one row up, wrapped to eight bits.
    pix_c = pix_rd_a_q[prv];
    pl    = s1_q.left_ok ? pix_left_q : '0;
    pr    = s1_q.right_ok ? pix_rd_b_q[prv] : '0;
    pu    = s1_q.res_en ? pix_rd_a_q[cur] : '0;
    pd    = s1_q.pix;
    dx    = pl + pr - {pix_c[sdem_pkg::PixW-2:0], 1'b0};
    dy    = pu + pd - {pix_c[sdem_pkg::PixW-2:0], 1'b0};
    sq_x  = dx * dx;
    sq_y  = dy * dy;
    sq_sum = {1'b0, sq_x} + {1'b0, sq_y};
    if (!s1_q.mag_en) begin
      new_mag = '0;
    end else if (sq_sum > (2*sdem_pkg::PixW+1)'(sdem_pkg::MagMax)) begin
      new_mag = sdem_pkg::MagMax;
    end else begin
      new_mag = sq_sum[sdem_pkg::PixW-1:0];
    end

    // Magnitudes two rows up; a value written by the item just ahead comes
    // from the forwarding register rather than the stale read.
    mc     = fwd_c_q ? fwd_val_q : mag_rd_a_q[cur];
    mr_eff = fwd_r_q ? fwd_val_q : mag_rd_b_q[cur];
    mu_eff = fwd_u_q ? fwd_val_q : mag_rd_a_q[prv];
    ml     = s1_q.left_ok ? mag_left_q : '0;
    mr     = s1_q.right_ok ? mr_eff : '0;
    mu     = s1_q.mag_up_ok ? mu_eff : '0;
    mark   = (mc == '0) || ((ml != '0) && (mr == '0)) ||
             ((mu != '0) && (new_mag == '0));

    s1_leave = s1_valid_q && (!s1_q.res_en || !out_valid_q || out_ready_i);
    pop_o    = q_valid_i && (!s1_valid_q || s1_leave);
    h_col_nx = q_item_i.col + sdem_pkg::ColW'(1);

    // The leaving item writes bank prv at its column in this same edge.
    fwd_c_d = s1_leave && (prv == q_item_i.par) && (s1_q.col == q_item_i.col);
    fwd_r_d = s1_leave && (prv == q_item_i.par) && (s1_q.col == h_col_nx);
    fwd_u_d = s1_leave && (prv != q_item_i.par) && (s1_q.col == q_item_i.col);

    s1_valid_d = pop_o ? 1'b1 : (s1_leave ? 1'b0 : s1_valid_q);

    out_valid_d = out_valid_q;
    if (s1_leave && s1_q.res_en) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Row buffers: read-first, so an item sees the value it overwrites.
  always_ff @(posedge clk_i) begin
    for (int b = 0; b < 2; b++) begin
      if (pop_o && (q_item_i.par == 1'(b))) begin
        pix_mem[b][q_item_i.col] <= q_item_i.pix;
      end
      if (s1_leave && (prv == 1'(b))) begin
        mag_mem[b][s1_q.col] <= new_mag;
      end
      if (pop_o) begin
        pix_rd_a_q[b] <= pix_mem[b][q_item_i.col];
        pix_rd_b_q[b] <= pix_mem[b][h_col_nx];
        mag_rd_a_q[b] <= mag_mem[b][q_item_i.col];
        mag_rd_b_q[b] <= mag_mem[b][h_col_nx];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      s1_q       <= q_item_i;
      pix_left_q <= pix_c;
      mag_left_q <= mc;
      fwd_val_q  <= new_mag;
      fwd_c_q    <= fwd_c_d;
      fwd_r_q    <= fwd_r_d;
      fwd_u_q    <= fwd_u_d;
    end
    if (s1_leave && s1_q.res_en) begin
      edge_q <= mark ? sdem_pkg::EdgeMark : sdem_pkg::EdgeNone;
      last_q <= s1_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign edge_res_o  = edge_q;
  assign last_o      = last_q;

endmodule

/* src/second_derivative_edge_map.sv */
// ----------------------------------------------------------------------------
// second_derivative_edge_map: streaming Laplacian zero-crossing edge marker
// Grey pixels in raster order are turned into squared second-difference
// magnitudes and then into 255/0 edge marks, two rows behind the input.
//
//   channel  direction  handshake              payload
//   in       input      in_valid_i/in_ready_o  func_i, pixel_i
//   out      output     out_valid_o/out_ready_i edge_res_o, last_o
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle is sustained in both directions while the output is not
// stalled; a result is offered once the beat that releases it has passed the
// queue, then the buffer read and compute, then the result register.
// The rate is set by the single read of both row buffers per beat.
// Reset clears the position and all valid flags and loads the reset geometry;
// the row buffers are left as they are and unwritten entries are never used.
// An output stall fills the four-entry queue, after which in_ready_o drops.
// ----------------------------------------------------------------------------
module second_derivative_edge_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           func_i,
  input  logic [sdem_pkg::PixW-1:0]      pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sdem_pkg::PixW-1:0]      edge_res_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sdem_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sdem_pkg::CfgDataW-1:0]  cfg_data_i
);

  sdem_pkg::item_t front_item, queue_item;
  logic            push, q_full, q_valid, pop;

  sdem_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .pixel_i     (pixel_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (front_item)
  );

  sdem_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (queue_item)
  );

  sdem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (queue_item),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .edge_res_o  (edge_res_o),
    .last_o      (last_o)
  );

endmodule

/* src/sdem_checker.sv */
// ----------------------------------------------------------------------------
// sdem_checker: port-level checks of the edge map
// Watches the top-level ports only and is attached by the bind below.
// ----------------------------------------------------------------------------
module sdem_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [sdem_pkg::PixW-1:0]      edge_res_o,
  input logic                           last_o
);

  // A stalled result beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(edge_res_o) && $stable(last_o))
    else $error("result beat changed while stalled");

  // A mark is either full scale or zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (edge_res_o == sdem_pkg::EdgeMark) ||
                    (edge_res_o == sdem_pkg::EdgeNone))
    else $error("edge mark out of range");

  // No result can be ready in the first cycle after reset.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_o)
    else $error("result straight after reset");

  // The input side only backs up behind a stalled output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_o) |-> $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output back-pressure");

endmodule

bind second_derivative_edge_map sdem_checker u_sdem_checker (.*);

/* bench/sdem_mark_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sdem_mark_checker: result checker for the edge map
// Follows the input, configuration and result channels of the block. It keeps
// its own row buffers and frame position, predicts the mark that each accepted
// input beat releases and compares each result beat with the oldest mark due.
// ----------------------------------------------------------------------------
module sdem_mark_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          func_i,
  input  logic [sdem_pkg::PixW-1:0]     pixel_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic [sdem_pkg::PixW-1:0]     edge_res_i,
  input  logic                          last_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [sdem_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sdem_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                   pending_o,
  output int unsigned                   errors_o,
  output int unsigned                   checked_o
);

  typedef struct packed {
    logic [sdem_pkg::PixW-1:0] mark;
    logic                      last;
  } mark_t;

  logic [sdem_pkg::WidthW-1:0]  width_reg;
  logic [sdem_pkg::HeightW-1:0] height_reg;
  logic [sdem_pkg::PixW-1:0]    pix_line [2*sdem_pkg::MaxWidth];
  logic [sdem_pkg::PixW-1:0]    mag_line [2*sdem_pkg::MaxWidth];
  int unsigned                  next_row;
  int unsigned                  next_col;
  mark_t                        marks_due [$];
  int unsigned                  err_cnt;
  int unsigned                  beat_cnt;

  function automatic int unsigned wrapped_sq(input int unsigned a, input int unsigned b,
                                             input int unsigned c);
    logic [7:0]  d;
    int unsigned dd;
    d  = 8'(a + b - 2 * c);
    dd = d;
    return dd * dd;
  endfunction

  // Advances the frame position by one beat (a flush inside the frame is dropped)
  // and gives any mark that the beat releases, two rows behind the input.
  function automatic bit predict_mark(input logic is_flush,
                                      input logic [sdem_pkg::PixW-1:0] pix,
                                      output mark_t m);
    int unsigned w, h, row, col, x, cur, prv, up_pix, up_mag, new_mag;
    int unsigned lft, ctr, rgt, upv, dnv, s, q;
    bit          has;
    m       = '0;
    has     = 1'b0;
    new_mag = 0;
    w = (width_reg == 0) ? 1 :
        ((width_reg > sdem_pkg::MaxWidth) ? sdem_pkg::MaxWidth : width_reg);
    h = (height_reg == 0) ? 1 :
        ((height_reg > sdem_pkg::MaxHeight) ? sdem_pkg::MaxHeight : height_reg);
    row = next_row;
    col = next_col;
    if (col >= w || row > h + 1) begin
      row = 0;
      col = 0;
    end
    x = pix;
    if (row < h) begin
      if (is_flush == sdem_pkg::FuncFlush) return 1'b0;
    end else begin
      x = 0;
    end
    cur = (row & 1) * sdem_pkg::MaxWidth;
    prv = ((row + 1) & 1) * sdem_pkg::MaxWidth;

    // Magnitude of the pixel one row up, now that its lower neighbour is here.
    up_pix = pix_line[cur + col];
    if (row >= 1 && row - 1 < h) begin
      lft = (col > 0) ? pix_line[prv + col - 1] : 0;
      ctr = pix_line[prv + col];
      rgt = (col + 1 < w) ? pix_line[prv + col + 1] : 0;
      upv = (row - 1 > 0) ? up_pix : 0;
      dnv = (row < h) ? x : 0;
      s = wrapped_sq(lft, rgt, ctr) + wrapped_sq(upv, dnv, ctr);
      new_mag = (s > 255) ? 255 : s;
    end
    pix_line[cur + col] = sdem_pkg::PixW'(x);

    up_mag = mag_line[prv + col];
    if (row >= 2) begin
      q   = row - 2;
      ctr = mag_line[cur + col];
      lft = (col > 0) ? mag_line[cur + col - 1] : 0;
      rgt = (col + 1 < w) ? mag_line[cur + col + 1] : 0;
      upv = (q > 0) ? up_mag : 0;
      dnv = (q + 1 < h) ? new_mag : 0;
      m.mark = (ctr == 0 || (lft > 0 && rgt == 0) || (upv > 0 && dnv == 0)) ?
               sdem_pkg::EdgeMark : sdem_pkg::EdgeNone;
      m.last = (q == h - 1 && col == w - 1);
      has = 1'b1;
    end
    mag_line[prv + col] = sdem_pkg::PixW'(new_mag);

    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h + 2) row = 0;
    end
    next_row = row;
    next_col = col;
    return has;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mark_t due;
    mark_t seen;
    if (!rst_ni) begin
      width_reg  = sdem_pkg::WidthReset;
      height_reg = sdem_pkg::HeightReset;
      next_row   = 0;
      next_col   = 0;
      err_cnt    = 0;
      beat_cnt   = 0;
      marks_due.delete();
      for (int i = 0; i < 2 * sdem_pkg::MaxWidth; i++) begin
        pix_line[i] = '0;
        mag_line[i] = '0;
      end
    end else begin
      // Any write to a known register abandons the frame in progress.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          sdem_pkg::CfgImageWidth: begin
            width_reg = cfg_data_i[sdem_pkg::WidthW-1:0];
            next_row  = 0;
            next_col  = 0;
          end
          sdem_pkg::CfgImageHeight: begin
            height_reg = cfg_data_i[sdem_pkg::HeightW-1:0];
            next_row   = 0;
            next_col   = 0;
          end
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (predict_mark(func_i, pixel_i, due)) marks_due.push_back(due);
      end
      if (out_valid_i && out_ready_i) begin
        seen = '{mark: edge_res_i, last: last_i};
        beat_cnt++;
        if (marks_due.size() == 0) begin
          err_cnt++;
          $display("%0t: result beat %0d with nothing due: expected none, got mark %0d last %0b",
                   $time, beat_cnt, seen.mark, seen.last);
        end else begin
          due = marks_due.pop_front();
          if (seen !== due) begin
            err_cnt++;
            $display("%0t: result beat %0d: expected mark %0d last %0b, got mark %0d last %0b",
                     $time, beat_cnt, due.mark, due.last, seen.mark, seen.last);
          end
        end
      end
    end
    pending_o <= marks_due.size();
    errors_o  <= err_cnt;
    checked_o <= beat_cnt;
  end

endmodule

/* bench/tb_second_derivative_edge_map.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_second_derivative_edge_map: stimulus and verdict for the edge map
// Drives pixel and flush beats in whole, broken and abandoned frames over many
// geometries, with random gaps on both channels, a long output hold-off and
// pauses until the pipeline is empty. The checker beside the block predicts
// and compares every result.
// ----------------------------------------------------------------------------
module tb_second_derivative_edge_map;

  localparam int MaxGap       = 11;
  localparam int SettleCycles = 12;
  localparam int HoldCycles   = 200;
  localparam int RandomBeats  = 1650;
  localparam int LimitNs      = 3_000_000;

  localparam logic [sdem_pkg::CfgIdxW-1:0] CfgUnused = sdem_pkg::CfgIdxW'(14);

  typedef enum int {
    StyleNoise,
    StyleLow,
    StyleTwoLevel,
    StyleFlat,
    StyleExtreme
  } frame_style_e;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          func      = sdem_pkg::FuncPixel;
  logic [sdem_pkg::PixW-1:0]     pixel     = '0;
  logic                          out_ready = 1'b0;
  logic                          cfg_valid = 1'b0;
  logic [sdem_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [sdem_pkg::CfgDataW-1:0] cfg_data  = '0;
  logic                          in_ready;
  logic                          out_valid;
  logic                          cfg_ready;
  logic [sdem_pkg::PixW-1:0]     edge_res;
  logic                          last;
  int unsigned                   pending;
  int unsigned                   errors;
  int unsigned                   checked;

  bit in_gaps  = 1'b1;
  bit out_gaps = 1'b1;
  bit hold_req = 1'b0;
  int cur_w    = 640;
  int cur_h    = 480;
  int fed      = 0;
  int beats    = 0;
  int frames   = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  second_derivative_edge_map DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (func),
    .pixel_i     (pixel),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .edge_res_o  (edge_res),
    .last_o      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  sdem_mark_checker marks_chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (func),
    .pixel_i     (pixel),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .edge_res_i  (edge_res),
    .last_i      (last),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors),
    .checked_o   (checked)
  );

  initial begin
    #(LimitNs);
    $display("tb_second_derivative_edge_map: done, errors");
    $finish;
  end

  // Result side: a random wait before each beat, and a long hold-off on request.
  initial begin : sink
    int gap;
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_req <= 1'b0;
      end
      gap = out_gaps ? $urandom_range(0, MaxGap) : 0;
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && !hold_req);
    end
  end

  function automatic int fit_size(input int v, input int hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [sdem_pkg::PixW-1:0] pick_pixel(
      input frame_style_e style, input logic [sdem_pkg::PixW-1:0] base);
    case (style)
      StyleLow:      return sdem_pkg::PixW'($urandom_range(0, 3));
      StyleTwoLevel: return $urandom_range(0, 1) ? base : '0;
      StyleFlat:     return base;
      StyleExtreme:  return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:       return sdem_pkg::PixW'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic f, input logic [sdem_pkg::PixW-1:0] p);
    int gap;
    gap = in_gaps ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    pixel    <= p;
    do @(posedge clk); while (!in_ready);
    beats++;
  endtask

  // Stops sending and waits until every due mark is out and the pipeline is quiet.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [sdem_pkg::CfgIdxW-1:0] idx,
                           input logic [sdem_pkg::CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_geometry(input logic [sdem_pkg::CfgDataW-1:0] wv,
                              input logic [sdem_pkg::CfgDataW-1:0] hv);
    settle();
    cfg_write(sdem_pkg::CfgImageWidth, wv);
    cfg_write(sdem_pkg::CfgImageHeight, hv);
    cfg_valid <= 1'b0;
    cur_w = fit_size(int'(wv[sdem_pkg::WidthW-1:0]), sdem_pkg::MaxWidth);
    cur_h = fit_size(int'(hv[sdem_pkg::HeightW-1:0]), sdem_pkg::MaxHeight);
  endtask

  // Sends pixels first..upto-1 of a frame; a complete frame is then drained.
  // With noise, stray flushes land among the pixels and stray pixels in the drain.
  task automatic run_frame(input frame_style_e style, input int noise, input int first,
                           input int upto);
    logic [sdem_pkg::PixW-1:0] base;
    base = sdem_pkg::PixW'($urandom_range(0, 255));
    for (int n = first; n < upto; n++) begin
      if ($urandom_range(0, 99) < noise) begin
        send_item(sdem_pkg::FuncFlush, sdem_pkg::PixW'($urandom));
      end
      send_item(sdem_pkg::FuncPixel, pick_pixel(style, base));
      fed++;
    end
    if (upto == cur_w * cur_h) begin
      for (int n = 0; n < 2 * cur_w; n++) begin
        if ($urandom_range(0, 99) < noise) begin
          send_item(sdem_pkg::FuncPixel, sdem_pkg::PixW'($urandom));
        end else begin
          send_item(sdem_pkg::FuncFlush, sdem_pkg::PixW'($urandom));
        end
        fed++;
      end
      frames++;
    end
  endtask

  initial begin : stimulus
    logic [sdem_pkg::PixW-1:0] pattern [9];
    frame_style_e              style;
    bit                        reconfig;
    pattern = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd7, 8'd0, 8'd128};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry is far too large to finish; these beats can give nothing yet.
    send_item(sdem_pkg::FuncPixel, 8'hFF);
    send_item(sdem_pkg::FuncFlush, 8'h00);
    send_item(sdem_pkg::FuncPixel, 8'h00);

    set_geometry(3, 3);
    for (int n = 0; n < 9; n++) begin
      if (n == 4) send_item(sdem_pkg::FuncFlush, 8'h3C);
      send_item(sdem_pkg::FuncPixel, pattern[n]);
    end
    for (int n = 0; n < 6; n++) begin
      send_item((n == 1) ? sdem_pkg::FuncPixel : sdem_pkg::FuncFlush, 8'hAA);
    end

    // Zero sizes clamp to one pixel; two frames back to back.
    set_geometry(0, 0);
    send_item(sdem_pkg::FuncPixel, 8'd200);
    send_item(sdem_pkg::FuncFlush, 8'h00);
    send_item(sdem_pkg::FuncPixel, 8'h55);
    send_item(sdem_pkg::FuncPixel, 8'h00);
    send_item(sdem_pkg::FuncFlush, 8'hFF);
    send_item(sdem_pkg::FuncFlush, 8'h00);
    frames += 2;

    // Bit 11 of the width write lies outside the register.
    set_geometry(12'h805, 2);
    run_frame(StyleExtreme, 10, 0, 10);

    // A write to an unused index must leave the frame running.
    set_geometry(6, 4);
    run_frame(StyleNoise, 0, 0, 11);
    settle();
    cfg_write(CfgUnused, 12'hFFF);
    cfg_valid <= 1'b0;
    run_frame(StyleNoise, 10, 11, 24);

    // Output held off while input keeps coming, so the block has to stall.
    set_geometry(10, 6);
    in_gaps = 1'b0;
    hold_req <= 1'b1;
    run_frame(StyleNoise, 0, 0, 60);
    in_gaps = 1'b1;

    fed      = 0;
    reconfig = 1'b1;
    while (fed < RandomBeats) begin
      if (reconfig || $urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 9) == 0) set_geometry($urandom_range(13, 40), $urandom_range(1, 3));
        else set_geometry($urandom_range(1, 12), $urandom_range(1, 8));
        reconfig = 1'b0;
      end
      in_gaps = ($urandom_range(0, 3) != 0);
      out_gaps <= ($urandom_range(0, 3) != 0);
      style = frame_style_e'($urandom_range(0, 4));
      if ($urandom_range(0, 7) == 0) begin
        // Broken off part way; the next geometry write starts a fresh frame.
        run_frame(style, 10, 0, $urandom_range(0, cur_w * cur_h - 1));
        reconfig = 1'b1;
      end else begin
        run_frame(style, $urandom_range(0, 1) ? 0 : 15, 0, cur_w * cur_h);
        if ($urandom_range(0, 14) == 0) settle();
      end
    end

    settle();
    $display("Run summary: %0d input beats, %0d complete frames, %0d result beats checked.",
             beats, frames, checked);
    $display("Geometry spanned one pixel up to 40-wide rows, with clamped and masked writes.");
    if (errors == 0) begin
      $display("tb_second_derivative_edge_map: done, clean");
    end else begin
      $display("tb_second_derivative_edge_map: done, errors");
    end
    $finish;
  end

endmodule
